// ----- hdl/rhh_pkg.sv -----
// shared types and constants for the robin hood hash table
// no dependencies
package rhh_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int PSL_W    = IDX_W + 2;
   localparam int PROBE_W  = 8;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 64;
   localparam int LIM_W    = 9;
   localparam int REQ_W    = 136;
   localparam int RSP_W    = 72;

   typedef enum logic [1:0] {
      MODE_GET = 2'd0,
      MODE_SET = 2'd1,
      MODE_DEL = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_FULL  = 2'd1,
      SLOT_TOMB  = 2'd2,
      SLOT_RSVD  = 2'd3
   } slot_type;

   typedef enum logic [2:0] {
      ST_GET_HIT  = 3'd0,
      ST_GET_MISS = 3'd1,
      ST_SET_NEW  = 3'd2,
      ST_SET_UPD  = 3'd3,
      ST_DELETED  = 3'd4,
      ST_DEL_MISS = 3'd5,
      ST_FULL     = 3'd6,
      ST_RSVD     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LK_RD,
      S_LK_EV,
      S_IN_RD,
      S_IN_EV,
      S_RESP
   } fsm_type;

   typedef struct packed {
      logic             load;
      logic             mem_rd;
      logic             lk_adv;
      logic             wr_value;
      logic             wr_tomb;
      logic             ins_start;
      logic             ins_put;
      logic             ins_swap;
      logic             ins_adv;
      logic             res_load;
      status_type       res_status;
      logic             res_hit_value;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     stop;        // empty slot or probe length passed stored one
      logic     hit;
      logic     slot_full;
      logic     psl_gt;
      logic     last_step;
      logic     table_full;
   } stat_type;

endpackage

// ----- hdl/robin_hood_hash_table_top.sv -----
// top level of the robin hood hash table: controller plus datapath
// depends on rhh_pkg, rhh_ctrl, rhh_dpath
//
// usage:
//   req channel carries one operation word: get, set, delete or no-op of a key with
//   its precomputed hash and a value; rsp channel returns one word per request
//   with a status code and the stored value on a get hit.
//   csr_we/csr_wdata write the insert limit (max_entries, reset 230).
// sequencing:
//   one request at a time. each probed slot takes a memory read state, then
//   a compare state; a set that inserts probes again from the home slot the
//   same way, then the response word is held until taken.
// reset:
//   synchronous; all slots read as empty at once via per-slot valid flops,
//   used count cleared, limit back to 230. no clearing pass.
// stall:
//   while rsp_tready is low the result word holds and no request is taken.
module robin_hood_hash_table_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // mode[1:0], key_id[33:2], key_hash[65:34], value_in[129:66], zero pad
   input  logic [rhh_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[2:0], value_out[66:3], zero pad
   output logic [rhh_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_we,
   input  logic [rhh_pkg::LIM_W-1:0]  csr_wdata
);
   import rhh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rhh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (mode_type'(req_tdata[1:0])),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rhh_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- hdl/rhh_dpath.sv -----
// datapath: slot memory, probe index and length, carried entry, used count, result
// depends on rhh_pkg
module rhh_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rhh_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        csr_we,
   input  logic [rhh_pkg::LIM_W-1:0]   csr_wdata,
   input  rhh_pkg::cmd_type            cmd,
   output rhh_pkg::stat_type           stat,
   output logic [rhh_pkg::RSP_W-1:0]   rsp_tdata
);
   import rhh_pkg::*;

   localparam int WORD_W = 2 + PROBE_W + KEY_W + VAL_W;

   logic [WORD_W-1:0]  mem [CAPACITY];
   logic [CAPACITY-1:0] vld_ff;
   logic [WORD_W-1:0]  rd_ff;
   logic               rd_vld_ff;

   logic [LIM_W-1:0]   max_ff;
   logic [CNT_W-1:0]   used_ff, used_in;
   mode_type           mode_ff;
   logic [KEY_W-1:0]   hash_ff;
   logic [KEY_W-1:0]   ck_ff, ck_in;
   logic [VAL_W-1:0]   cv_ff, cv_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PSL_W-1:0]   psl_ff, psl_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   status_type         res_st_ff;
   logic [VAL_W-1:0]   res_val_ff;

   slot_type           d_state;
   logic [PROBE_W-1:0] d_probe;
   logic [KEY_W-1:0]   d_key;
   logic [VAL_W-1:0]   d_val;
   logic               wr_en;
   logic [WORD_W-1:0]  wr_data;
   logic [PROBE_W-1:0] psl_sat;
   logic [CNT_W-1:0]   limit;

   assign d_state = rd_vld_ff ? slot_type'(rd_ff[WORD_W-1 -: 2]) : SLOT_EMPTY;
   assign d_probe = rd_ff[KEY_W+VAL_W +: PROBE_W];
   assign d_key   = rd_ff[VAL_W +: KEY_W];
   assign d_val   = rd_ff[VAL_W-1:0];

   assign psl_sat = (psl_ff > PSL_W'({PROBE_W{1'b1}})) ? {PROBE_W{1'b1}}
                                                       : psl_ff[PROBE_W-1:0];
   assign limit   = (CNT_W'(max_ff) > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                        : CNT_W'(max_ff);

   always_comb begin
      stat.mode       = mode_ff;
      stat.slot_full  = (d_state == SLOT_FULL);
      stat.psl_gt     = psl_ff > PSL_W'(d_probe);
      stat.stop       = (d_state == SLOT_EMPTY) || stat.psl_gt;
      stat.hit        = !stat.stop && stat.slot_full && (d_key == ck_ff);
      stat.last_step  = (step_ff == CNT_W'(CAPACITY - 1));
      stat.table_full = used_ff >= limit;
   end

   // write data for the slot under the probe index
   always_comb begin
      wr_en   = 1'b0;
      wr_data = rd_ff;
      if (cmd.wr_value) begin
         wr_en   = 1'b1;
         wr_data = {SLOT_FULL, d_probe, d_key, cv_ff};
      end else if (cmd.wr_tomb) begin
         wr_en   = 1'b1;
         wr_data = {SLOT_TOMB, d_probe, d_key, d_val};
      end else if (cmd.ins_put || cmd.ins_swap) begin
         wr_en   = 1'b1;
         wr_data = {SLOT_FULL, psl_sat, ck_ff, cv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[idx_ff] <= 1'b1;
         end
         if (cmd.mem_rd) begin
            rd_vld_ff <= vld_ff[idx_ff];
         end
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      psl_in  = psl_ff;
      step_in = step_ff;
      ck_in   = ck_ff;
      cv_in   = cv_ff;
      used_in = used_ff;
      if (cmd.load) begin
         idx_in  = req_tdata[34 +: IDX_W];
         psl_in  = '0;
         step_in = '0;
         ck_in   = req_tdata[2 +: KEY_W];
         cv_in   = req_tdata[66 +: VAL_W];
      end else if (cmd.ins_start) begin
         idx_in  = hash_ff[IDX_W-1:0];
         psl_in  = '0;
         step_in = '0;
      end else if (cmd.lk_adv || cmd.ins_adv) begin
         idx_in  = idx_ff + 1'b1;
         psl_in  = psl_ff + 1'b1;
         step_in = step_ff + 1'b1;
      end else if (cmd.ins_swap) begin
         // carry the displaced entry onward
         idx_in  = idx_ff + 1'b1;
         psl_in  = PSL_W'(d_probe) + 1'b1;
         step_in = step_ff + 1'b1;
         ck_in   = d_key;
         cv_in   = d_val;
      end
      if (cmd.ins_put && d_state == SLOT_EMPTY) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= LIM_W'(230);
         used_ff <= '0;
      end else begin
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      psl_ff  <= psl_in;
      step_ff <= step_in;
      ck_ff   <= ck_in;
      cv_ff   <= cv_in;
      if (cmd.load) begin
         mode_ff <= mode_type'(req_tdata[1:0]);
         hash_ff <= req_tdata[34 +: KEY_W];
      end
      if (cmd.res_load) begin
         res_st_ff  <= cmd.res_status;
         res_val_ff <= cmd.res_hit_value ? d_val : '0;
      end
   end

   assign rsp_tdata = {{(RSP_W - 3 - VAL_W){1'b0}}, res_val_ff, res_st_ff};

endmodule

// ----- hdl/rhh_ctrl.sv -----
// controller state machine sequencing lookup, insert and response
// depends on rhh_pkg
module rhh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  rhh_pkg::mode_type  req_mode,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rhh_pkg::stat_type  stat,
   output rhh_pkg::cmd_type   cmd
);
   import rhh_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.res_status = ST_GET_MISS;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_mode == MODE_NOP) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_GET_MISS;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_LK_RD;
               end
            end
         end
         S_LK_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_LK_EV;
         end
         S_LK_EV: begin
            if (stat.hit) begin
               cmd.res_load = 1'b1;
               state_in     = S_RESP;
               case (stat.mode)
                  MODE_GET: begin
                     cmd.res_status    = ST_GET_HIT;
                     cmd.res_hit_value = 1'b1;
                  end
                  MODE_SET: begin
                     cmd.wr_value   = 1'b1;
                     cmd.res_status = ST_SET_UPD;
                  end
                  MODE_DEL: begin
                     cmd.wr_tomb    = 1'b1;
                     cmd.res_status = ST_DELETED;
                  end
                  default: cmd.res_status = ST_GET_MISS;
               endcase
            end else if (stat.stop || stat.last_step) begin
               case (stat.mode)
                  MODE_SET: begin
                     if (stat.table_full) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_in       = S_RESP;
                     end else begin
                        cmd.ins_start = 1'b1;
                        state_in      = S_IN_RD;
                     end
                  end
                  MODE_DEL: begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_DEL_MISS;
                     state_in       = S_RESP;
                  end
                  default: begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_GET_MISS;
                     state_in       = S_RESP;
                  end
               endcase
            end else begin
               cmd.lk_adv = 1'b1;
               state_in   = S_LK_RD;
            end
         end
         S_IN_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_IN_EV;
         end
         S_IN_EV: begin
            if (!stat.slot_full) begin
               cmd.ins_put    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_SET_NEW;
               state_in       = S_RESP;
            end else begin
               if (stat.psl_gt) begin
                  cmd.ins_swap = 1'b1;
               end else begin
                  cmd.ins_adv = 1'b1;
               end
               if (stat.last_step) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_FULL;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_IN_RD;
               end
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
